>>> rtl/slcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg - shared types and constants of the segment LCD frame formatter
// Stage words, segment codes, range limits and the constant-divide helpers.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // range limits of the large reading, in tenths
  localparam logic signed [15:0] BIG_HI_LIMIT = 16'sd19995;
  localparam logic signed [15:0] BIG_LO_LIMIT = -16'sd995;
  localparam logic signed [15:0] BIG_DP_HI    = 16'sd1995;
  localparam logic signed [15:0] BIG_DP_LO    = -16'sd95;
  localparam logic [14:0]        BIG_ROUND    = 15'd5;

  // range limits of the small reading
  localparam logic signed [15:0] SM_HI_LIMIT = 16'sd99;
  localparam logic signed [15:0] SM_LO_LIMIT = -16'sd9;

  // reciprocal multipliers for divide by ten
  localparam logic [15:0] DIV10_MUL_WIDE  = 16'd52429;  // >> 19
  localparam logic [7:0]  DIV10_MUL_NARROW = 8'd205;    // >> 11

  // segment codes
  localparam logic [7:0] SEG_H        = 8'h67;
  localparam logic [7:0] SEG_I        = 8'h20;
  localparam logic [7:0] SEG_L        = 8'hE0;
  localparam logic [7:0] SEG_O        = 8'hA6;
  localparam logic [7:0] SEG_MINUS    = 8'h04;
  localparam logic [7:0] SEG_LEAD_ONE = 8'h08;
  localparam logic [7:0] SEG_DP       = 8'h08;
  localparam logic [7:0] SEG_FLAG     = 8'h08;

  typedef struct packed {
    logic [2:0] unit_symbol;
    logic [2:0] smiley_mode;
    logic       ble_on;
    logic       battery_on;
    logic       percent_on;
  } side_t;

  // after classification
  typedef struct packed {
    logic        big_hi;
    logic        big_lo;
    logic        big_neg;
    logic        big_round;
    logic [14:0] big_mag;
    logic        sm_hi;
    logic        sm_lo;
    logic        sm_neg;
    logic [6:0]  sm_mag;
    side_t       side;
  } cls_t;

  // after rounding to whole units where needed
  typedef struct packed {
    logic        big_hi;
    logic        big_lo;
    logic        big_neg;
    logic        big_dp;
    logic [10:0] big_val;
    logic        sm_hi;
    logic        sm_lo;
    logic        sm_neg;
    logic [6:0]  sm_mag;
    side_t       side;
  } scl_t;

  // after the first digit split
  typedef struct packed {
    logic       big_hi;
    logic       big_lo;
    logic       big_neg;
    logic       big_dp;
    logic       big_thou;
    logic       big_gt99;
    logic [7:0] big_q10;
    logic [3:0] big_u;
    logic       sm_hi;
    logic       sm_lo;
    logic       sm_neg;
    logic       sm_gt9;
    logic [3:0] sm_t;
    logic [3:0] sm_u;
    side_t      side;
  } spl_t;

  typedef struct packed {
    logic [7:0] seg_byte0;
    logic [7:0] seg_byte1;
    logic [7:0] seg_byte2;
    logic [7:0] seg_byte3;
    logic [7:0] seg_byte4;
    logic [7:0] seg_byte5;
  } seg_t;

  function automatic logic [7:0] seg_digit(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hF3;
      4'd1:    s = 8'h03;
      4'd2:    s = 8'hB5;
      4'd3:    s = 8'h97;
      4'd4:    s = 8'h47;
      4'd5:    s = 8'hD6;
      4'd6:    s = 8'hF6;
      4'd7:    s = 8'h13;
      4'd8:    s = 8'hF7;
      4'd9:    s = 8'hD7;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/slcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_if - frame and segment channels
// Valid/ready channels carrying one display frame and one set of segment bytes.
// ----------------------------------------------------------------------------
interface slcd_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] big_value;
  logic signed [15:0] small_value;
  logic               percent_on;
  logic [2:0]         unit_symbol;
  logic [2:0]         smiley_mode;
  logic               ble_on;
  logic               battery_on;

  modport source (
    output valid, big_value, small_value, percent_on, unit_symbol, smiley_mode,
           ble_on, battery_on,
    input  ready
  );
  modport sink (
    input  valid, big_value, small_value, percent_on, unit_symbol, smiley_mode,
           ble_on, battery_on,
    output ready
  );
endinterface

interface slcd_seg_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_byte0;
  logic [7:0] seg_byte1;
  logic [7:0] seg_byte2;
  logic [7:0] seg_byte3;
  logic [7:0] seg_byte4;
  logic [7:0] seg_byte5;

  modport source (
    output valid, seg_byte0, seg_byte1, seg_byte2, seg_byte3, seg_byte4, seg_byte5,
    input  ready
  );
  modport sink (
    input  valid, seg_byte0, seg_byte1, seg_byte2, seg_byte3, seg_byte4, seg_byte5,
    output ready
  );
endinterface

>>> rtl/segment_lcd_frame_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_lcd_frame_formatter - thermometer LCD frame to segment bytes
//
// frame_i takes one display frame per word: large reading in tenths, small
// reading, percent, unit symbol, smiley, connection and battery flags.
// seg_o gives the six segment bytes of the panel, one word per frame, in
// order. Both are valid/ready channels.
// Four register stages: classify, round to units, first digit split, final
// digit split and segment assembly into the output register. One frame is
// accepted every cycle unless seg_o holds a word that is not taken.
// The pipeline moves as one: when seg_o holds a word that is not taken, all
// stages hold and frame_i.ready drops; nothing is lost or repeated. Empty
// stages still advance while the output register is free.
// Reset clears the stage valid bits; no word is presented after reset.
// ----------------------------------------------------------------------------
module segment_lcd_frame_formatter import slcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_frame_if.sink  frame_i,
  slcd_seg_if.source  seg_o
);

  logic  adv;
  logic  s1_valid, s2_valid, s3_valid, s4_valid;
  side_t side;
  cls_t  cls;
  scl_t  scl;
  spl_t  spl;
  seg_t  seg;

  assign adv           = !s4_valid || seg_o.ready;
  assign frame_i.ready = adv;

  assign side.unit_symbol = frame_i.unit_symbol;
  assign side.smiley_mode = frame_i.smiley_mode;
  assign side.ble_on      = frame_i.ble_on;
  assign side.battery_on  = frame_i.battery_on;
  assign side.percent_on  = frame_i.percent_on;

  slcd_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (frame_i.valid),
    .big_value_i   (frame_i.big_value),
    .small_value_i (frame_i.small_value),
    .side_i        (side),
    .valid_o       (s1_valid),
    .cls_o         (cls)
  );

  slcd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_valid),
    .cls_i   (cls),
    .valid_o (s2_valid),
    .scl_o   (scl)
  );

  slcd_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s2_valid),
    .scl_i   (scl),
    .valid_o (s3_valid),
    .spl_o   (spl)
  );

  slcd_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s3_valid),
    .spl_i   (spl),
    .valid_o (s4_valid),
    .seg_o   (seg)
  );

  assign seg_o.valid     = s4_valid;
  assign seg_o.seg_byte0 = seg.seg_byte0;
  assign seg_o.seg_byte1 = seg.seg_byte1;
  assign seg_o.seg_byte2 = seg.seg_byte2;
  assign seg_o.seg_byte3 = seg.seg_byte3;
  assign seg_o.seg_byte4 = seg.seg_byte4;
  assign seg_o.seg_byte5 = seg.seg_byte5;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_i.ready |-> (seg_o.valid && !seg_o.ready))
    else $error("input stalled while output free");

  a_accept_enters_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_i.valid && frame_i.ready) |=> s1_valid)
    else $error("accepted word missing from stage 1");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid)
              && $stable(s4_valid)))
    else $error("pipeline moved during stall");

  a_byte3_spare_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> (seg_o.seg_byte3[1] == 1'b0 && seg_o.seg_byte3[3] == 1'b0))
    else $error("unused segment bits set");

endmodule

>>> rtl/slcd_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_classify - stage 1
// Range checks, sign and magnitude of both readings, rounding offset.
// ----------------------------------------------------------------------------
module slcd_classify import slcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic signed [15:0] big_value_i,
  input  logic signed [15:0] small_value_i,
  input  side_t              side_i,
  output logic               valid_o,
  output cls_t               cls_o
);

  logic        valid_q;
  cls_t        cls_d, cls_q;
  logic [15:0] big_abs;
  logic [15:0] sm_abs;

  always_comb begin
    big_abs = big_value_i[15] ? 16'(-big_value_i) : 16'(big_value_i);
    sm_abs  = small_value_i[15] ? 16'(-small_value_i) : 16'(small_value_i);

    cls_d.big_hi    = big_value_i > BIG_HI_LIMIT;
    cls_d.big_lo    = big_value_i < BIG_LO_LIMIT;
    cls_d.big_neg   = big_value_i[15];
    cls_d.big_round = (big_value_i > BIG_DP_HI) || (big_value_i < BIG_DP_LO);
    cls_d.big_mag   = big_abs[14:0] + (cls_d.big_round ? BIG_ROUND : 15'd0);
    cls_d.sm_hi     = small_value_i > SM_HI_LIMIT;
    cls_d.sm_lo     = small_value_i < SM_LO_LIMIT;
    cls_d.sm_neg    = small_value_i[15];
    cls_d.sm_mag    = sm_abs[6:0];
    cls_d.side      = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

>>> rtl/slcd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_scale - stage 2
// Large reading: tenths to whole units by reciprocal multiply where rounded.
// ----------------------------------------------------------------------------
module slcd_scale import slcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  cls_t cls_i,
  output logic valid_o,
  output scl_t scl_o
);

  logic        valid_q;
  scl_t        scl_d, scl_q;
  logic [30:0] prod;

  assign prod = 31'(cls_i.big_mag) * 31'(DIV10_MUL_WIDE);

  always_comb begin
    scl_d.big_hi  = cls_i.big_hi;
    scl_d.big_lo  = cls_i.big_lo;
    scl_d.big_neg = cls_i.big_neg;
    scl_d.big_dp  = !cls_i.big_round;
    scl_d.big_val = cls_i.big_round ? prod[29:19] : cls_i.big_mag[10:0];
    scl_d.sm_hi   = cls_i.sm_hi;
    scl_d.sm_lo   = cls_i.sm_lo;
    scl_d.sm_neg  = cls_i.sm_neg;
    scl_d.sm_mag  = cls_i.sm_mag;
    scl_d.side    = cls_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      scl_q <= scl_d;
    end
  end

  assign valid_o = valid_q;
  assign scl_o   = scl_q;

endmodule

>>> rtl/slcd_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_split - stage 3
// Units digit of the large reading, both digits of the small reading.
// ----------------------------------------------------------------------------
module slcd_split import slcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  scl_t scl_i,
  output logic valid_o,
  output spl_t spl_o
);

  logic        valid_q;
  spl_t        spl_d, spl_q;
  logic [26:0] prod_b;
  logic [14:0] prod_s;
  logic [10:0] big_rem;
  logic [6:0]  sm_rem;

  assign prod_b  = 27'(scl_i.big_val) * 27'(DIV10_MUL_WIDE);
  assign prod_s  = 15'(scl_i.sm_mag) * 15'(DIV10_MUL_NARROW);
  assign big_rem = scl_i.big_val - 11'(prod_b[26:19]) * 11'd10;
  assign sm_rem  = scl_i.sm_mag - 7'(prod_s[14:11]) * 7'd10;

  always_comb begin
    spl_d.big_hi   = scl_i.big_hi;
    spl_d.big_lo   = scl_i.big_lo;
    spl_d.big_neg  = scl_i.big_neg;
    spl_d.big_dp   = scl_i.big_dp;
    spl_d.big_thou = scl_i.big_val > 11'd999;
    spl_d.big_gt99 = scl_i.big_val > 11'd99;
    spl_d.big_q10  = prod_b[26:19];
    spl_d.big_u    = big_rem[3:0];
    spl_d.sm_hi    = scl_i.sm_hi;
    spl_d.sm_lo    = scl_i.sm_lo;
    spl_d.sm_neg   = scl_i.sm_neg;
    spl_d.sm_gt9   = scl_i.sm_mag > 7'd9;
    spl_d.sm_t     = prod_s[14:11];
    spl_d.sm_u     = sm_rem[3:0];
    spl_d.side     = scl_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      spl_q <= spl_d;
    end
  end

  assign valid_o = valid_q;
  assign spl_o   = spl_q;

endmodule

>>> rtl/slcd_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_encode - stage 4
// Tens and hundreds digits, segment lookup and byte assembly; output register.
// ----------------------------------------------------------------------------
module slcd_encode import slcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  spl_t spl_i,
  output logic valid_o,
  output seg_t seg_o
);

  logic        valid_q;
  seg_t        seg_d, seg_q;
  logic [15:0] prod;
  logic [4:0]  q100;
  logic [7:0]  tens_rem;
  logic [4:0]  hund;
  logic [7:0]  b0, b1, b2, b4, b5;

  assign prod     = 16'(spl_i.big_q10) * 16'(DIV10_MUL_NARROW);
  assign q100     = prod[15:11];
  assign tens_rem = spl_i.big_q10 - 8'(q100) * 8'd10;

  always_comb begin
    if (q100 >= 5'd20) begin
      hund = q100 - 5'd20;
    end else if (q100 >= 5'd10) begin
      hund = q100 - 5'd10;
    end else begin
      hund = q100;
    end
  end

  always_comb begin
    if (spl_i.big_hi) begin
      b0 = SEG_H;
      b1 = SEG_I;
      b2 = 8'h00;
    end else if (spl_i.big_lo) begin
      b0 = SEG_L;
      b1 = SEG_O;
      b2 = 8'h00;
    end else begin
      b0 = (spl_i.big_neg ? SEG_MINUS : 8'h00)
         | (spl_i.big_thou ? SEG_LEAD_ONE : 8'h00)
         | (spl_i.big_gt99 ? seg_digit(hund[3:0]) : 8'h00);
      // below ten the tens place reads zero, which the split already gives
      b1 = (spl_i.big_dp ? SEG_DP : 8'h00) | seg_digit(tens_rem[3:0]);
      b2 = seg_digit(spl_i.big_u);
    end

    if (spl_i.sm_hi) begin
      b4 = SEG_I;
      b5 = SEG_H;
    end else if (spl_i.sm_lo) begin
      b4 = SEG_O;
      b5 = SEG_L;
    end else begin
      b4 = (spl_i.sm_neg ? SEG_MINUS : 8'h00)
         | (spl_i.sm_gt9 ? seg_digit(spl_i.sm_t) : 8'h00);
      b5 = seg_digit(spl_i.sm_u);
    end

    seg_d.seg_byte0 = b0;
    seg_d.seg_byte1 = b1;
    seg_d.seg_byte2 = b2 | (spl_i.side.unit_symbol[1] ? SEG_FLAG : 8'h00);
    seg_d.seg_byte3 = {spl_i.side.unit_symbol[2], spl_i.side.battery_on,
                       spl_i.side.unit_symbol[0], spl_i.side.smiley_mode[2], 1'b0,
                       spl_i.side.smiley_mode[1], 1'b0, spl_i.side.smiley_mode[0]};
    seg_d.seg_byte4 = b4 | (spl_i.side.ble_on ? SEG_FLAG : 8'h00);
    seg_d.seg_byte5 = b5 | (spl_i.side.percent_on ? SEG_FLAG : 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule
